// ===== src/assert_macros.svh =====
// Assertion macros shared by the command receiver RTL.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/dbcr_pkg.sv =====
// Package of the display bus command receiver: item types, configuration
// types, command phases and constants. No dependencies.
`default_nettype none

package dbcr_pkg;

  localparam int PAYLOAD_BYTES_DEF = 11;
  localparam int PIDX_W            = 4;
  localparam int SEND_W            = 4;
  localparam int CFG_W             = 8;
  localparam int CFG_IDX_W         = 2;

  localparam logic [SEND_W-1:0] SEND_START = 4'd8;
  localparam logic [2:0]        BRIGHT_RST = 3'd7;

  // Bit positions within the error flags.
  localparam int ERR_PARTIAL  = 0;
  localparam int ERR_COUNT    = 1;
  localparam int ERR_OVERFLOW = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE_A = 2'd0,
    CFG_MODE_B = 2'd1,
    CFG_WRITE  = 2'd2,
    CFG_READ   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_MODE    = 2'd1,
    PH_CAPTURE = 2'd2,
    PH_BRIGHT  = 2'd3
  } phase_e;

  // Request type codes of an input item.
  localparam logic REQ_SELECT = 1'b0;
  localparam logic REQ_CLOCK  = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] mode_cmd_a;
    logic [CFG_W-1:0] mode_cmd_b;
    logic [CFG_W-1:0] write_cmd;
    logic [CFG_W-1:0] read_cmd;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic        line_level;
    logic        data_in;
    logic [15:0] button_code;
  } in_item_t;

  typedef struct packed {
    logic              data_out;
    logic              drive_data;
    logic              byte_done;
    logic [7:0]        byte_value;
    logic              payload_write;
    logic [PIDX_W-1:0] payload_index;
    logic              packet_ready;
    logic [2:0]        packet_fault;
    logic [2:0]        brightness;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/dbcr_stream_if.sv =====
// Valid/ready stream interface carrying one item of a configurable type.
// Used for the input and result channels; no dependencies.
`default_nettype none

interface dbcr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/dbcr_cfg_regs.sv =====
// Configuration registers of the command receiver (command byte values).
// Depends on dbcr_pkg.
`default_nettype none

module dbcr_cfg_regs
  import dbcr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE_A: cfg_d.mode_cmd_a = cfg_wdata_i;
        CFG_MODE_B: cfg_d.mode_cmd_b = cfg_wdata_i;
        CFG_WRITE:  cfg_d.write_cmd  = cfg_wdata_i;
        CFG_READ:   cfg_d.read_cmd   = cfg_wdata_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_cmd_a <= 8'd1;
      cfg_q.mode_cmd_b <= 8'd5;
      cfg_q.write_cmd  <= 8'd64;
      cfg_q.read_cmd   <= 8'd66;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/dbcr_core.sv =====
// Bus protocol state and the per-edge next-state logic of the receiver.
// Depends on dbcr_pkg.
`default_nettype none

module dbcr_core
  import dbcr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PAYLOAD_BYTES);

  logic              sel_q, sel_d;
  logic              drv_q, drv_d;
  logic [7:0]        shift_q, shift_d;
  logic [2:0]        bit_q, bit_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  phase_e            phase_q, phase_d;
  logic [2:0]        err_q, err_d;
  logic [SEND_W-1:0] send_q, send_d;
  logic [2:0]        bright_q, bright_d;

  logic [2:0] errs;
  logic       ready;

  always_comb begin
    sel_d    = sel_q;
    drv_d    = drv_q;
    shift_d  = shift_q;
    bit_d    = bit_q;
    cnt_d    = cnt_q;
    phase_d  = phase_q;
    err_d    = err_q;
    send_d   = send_q;
    bright_d = bright_q;
    errs     = err_q;
    ready    = 1'b0;
    res_o    = '0;

    if (item_i.req_type == REQ_SELECT) begin
      if (item_i.line_level) begin
        // Select rise closes the packet.
        sel_d = 1'b0;
        drv_d = 1'b0;
        if (cnt_q != CNT_FULL && cnt_q != '0) begin
          errs[ERR_COUNT] = 1'b1;
        end
        if (bit_q != 3'd0) begin
          errs[ERR_PARTIAL] = 1'b1;
        end
        cnt_d = '0;
        bit_d = 3'd0;
        if (shift_q == cfg_i.mode_cmd_a || shift_q == cfg_i.mode_cmd_b) begin
          phase_d = PH_MODE;
        end else if (shift_q == cfg_i.write_cmd) begin
          phase_d = (phase_q == PH_MODE) ? PH_CAPTURE : PH_IDLE;
        end else if (phase_q == PH_BRIGHT) begin
          bright_d = shift_q[2:0];
          phase_d  = PH_IDLE;
          ready    = 1'b1;
        end else if (phase_q == PH_CAPTURE) begin
          phase_d = PH_BRIGHT;
        end
        if (ready) begin
          res_o.packet_ready = 1'b1;
          res_o.packet_fault = errs;
          err_d              = '0;
        end else begin
          err_d = errs;
        end
      end else begin
        sel_d = 1'b1;
      end
    end else if (sel_q) begin
      if (!item_i.line_level && drv_q) begin
        res_o.data_out = item_i.button_code[send_q];
        send_d         = send_q + SEND_W'(1);
      end else if (item_i.line_level && !drv_q) begin
        shift_d = {item_i.data_in, shift_q[7:1]};
        bit_d   = bit_q + 3'd1;
        if (bit_q == 3'd7) begin
          res_o.byte_done = 1'b1;
          if (phase_q == PH_CAPTURE) begin
            if (cnt_q < CNT_FULL) begin
              res_o.payload_write = 1'b1;
              res_o.payload_index = PIDX_W'(cnt_q[IDX_W-1:0]);
              cnt_d               = cnt_q + CNT_W'(1);
            end else begin
              err_d[ERR_OVERFLOW] = 1'b1;
            end
          end else if (shift_d == cfg_i.read_cmd) begin
            send_d = SEND_START;
            drv_d  = 1'b1;
          end
        end
      end
    end

    res_o.drive_data = drv_d;
    res_o.byte_value = shift_d;
    res_o.brightness = bright_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q    <= 1'b0;
      drv_q    <= 1'b0;
      shift_q  <= 8'd0;
      bit_q    <= 3'd0;
      cnt_q    <= '0;
      phase_q  <= PH_IDLE;
      err_q    <= 3'd0;
      send_q   <= SEND_START;
      bright_q <= BRIGHT_RST;
    end else if (step_i) begin
      sel_q    <= sel_d;
      drv_q    <= drv_d;
      shift_q  <= shift_d;
      bit_q    <= bit_d;
      cnt_q    <= cnt_d;
      phase_q  <= phase_d;
      err_q    <= err_d;
      send_q   <= send_d;
      bright_q <= bright_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/display_bus_command_receiver.sv =====
// Top level of the display bus command receiver: input and result registers,
// configuration registers and protocol core. Depends on dbcr_pkg,
// dbcr_stream_if, dbcr_cfg_regs, dbcr_core and assert_macros.svh.
//
//   channel   direction  handshake      payload
//   in_i      sink       valid/ready    in_item_t  (one bus edge)
//   res_o     source     valid/ready    out_item_t (one result per edge)
//   cfg       write      cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// Every item yields exactly one result. An item is held in the input
// register, is processed as it moves to the result register, and is then
// valid at res_o for the sink to take; one item per cycle is sustained while
// the sink keeps ready high.
// Reset (rst_ni, asynchronous, active low) empties both registers and sets
// the protocol state and command bytes to their defaults.
// When the result register is held by the sink, the input register still
// takes an item if it is empty, so one item waits while one result waits.
`default_nettype none

`include "assert_macros.svh"

module display_bus_command_receiver
  import dbcr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  dbcr_stream_if.sink               in_i,
  dbcr_stream_if.source             res_o
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_v_q;
  out_item_t res_d, res_q;
  logic      res_v_q;
  logic      advance;

  // The held item moves on once the result register is free or being emptied.
  assign advance    = in_v_q && (!res_v_q || res_o.ready);
  assign in_i.ready = !in_v_q || advance;

  dbcr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dbcr_core #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // Input register: control part.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  // Input register: payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_i.payload;
    end
  end

  // Result register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (advance) begin
      res_v_q <= 1'b1;
    end else if (res_o.ready) begin
      res_v_q <= 1'b0;
    end
  end

  // Result register: payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid   = res_v_q;
  assign res_o.payload = res_q;

  // A bit is only driven while the data line is an output.
  `ASSERT_IMPLIES(a_drive_out, clk_i, rst_ni, res_v_q && res_q.data_out, res_q.drive_data)
  // Payload stores happen only on a completed byte.
  `ASSERT_IMPLIES(a_wr_byte, clk_i, rst_ni, res_v_q && res_q.payload_write, res_q.byte_done)
  // Errors are reported only with a ready packet.
  `ASSERT_IMPLIES(a_err_rdy, clk_i, rst_ni, res_v_q && !res_q.packet_ready,
                  res_q.packet_fault == 3'd0)
  // An empty result register never stalls the input side.
  `ASSERT_IMPLIES(a_in_ready, clk_i, rst_ni, !res_v_q, in_i.ready)
  // An item that moves on is shown as a result in the next cycle.
  `ASSERT_NEXT(a_advance, clk_i, rst_ni, advance, res_v_q)

endmodule

`default_nettype wire
